// ===== hdl/cdemod_pkg.sv =====
package cdemod_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SAMPLE_WIDTH     = 16;
   localparam int ACC_WIDTH        = 40;

   localparam int SINE_WIDTH  = 16;
   localparam int REF_WIDTH   = 20;
   localparam int CORR_WIDTH  = 40;
   localparam int WIDE_WIDTH  = 64;
   localparam int CNT_WIDTH   = 10;
   localparam int PHASE_WIDTH = 32;
   localparam int FRAC_SHIFT  = 14;
   localparam int GAIN_SHIFT  = 12;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = 5;

   localparam logic [1:0] MODE_ASK = 2'd0;
   localparam logic [1:0] MODE_PSK = 2'd1;
   localparam logic [1:0] MODE_FSK = 2'd2;

   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_STEP_A  = 3'd1;
   localparam logic [2:0] REG_STEP_B  = 3'd2;
   localparam logic [2:0] REG_GAIN    = 3'd3;
   localparam logic [2:0] REG_THR_LOW = 3'd4;
   localparam logic [2:0] REG_THR_HI  = 3'd5;
   localparam logic [2:0] REG_SPB     = 3'd6;

   localparam logic [1:0]         RST_MODE    = MODE_ASK;
   localparam logic [31:0]        RST_STEP_A  = 32'd85899346;
   localparam logic [31:0]        RST_STEP_B  = 32'd171798692;
   localparam logic [15:0]        RST_GAIN    = 16'd12288;
   localparam logic signed [31:0] RST_THR_LOW = 32'sd819200;
   localparam logic signed [31:0] RST_THR_HI  = 32'sd1638400;
   localparam logic [9:0]         RST_SPB     = 10'd100;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] K1       = 64'd1686629713;
   localparam logic [63:0] K3       = 64'd693598668;
   localparam logic [63:0] K5       = 64'd85569306;
   localparam logic [63:0] K7       = 64'd5026995;
   localparam logic [63:0] K9       = 64'd172272;
   localparam logic [63:0] SINE_MAX = 64'd16384;
   localparam logic [63:0] ROUND_Q  = 64'd32768;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        phase_step_a;
      logic [31:0]        phase_step_b;
      logic [15:0]        ref_gain;
      logic signed [31:0] thresh_low;
      logic signed [31:0] thresh_high;
      logic [9:0]         samples_per_bit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic ref_calc;
      logic prod_calc;
      logic acc;
      logic diff;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic period_end;
   } status_type;

   // quarter-wave folded odd polynomial, rounded to q1.14
   function automatic logic signed [SINE_WIDTH-1:0] sine_value(input int unsigned k,
                                                                input int unsigned idx_bits);
      logic [31:0] p;
      logic [1:0]  quad;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      p = 32'(k) << (32 - idx_bits);
      quad = p[31:30];
      z = {34'd0, p[29:0]};
      if (quad[0]) begin
         z = Q30_ONE - z;
      end
      z2 = (z * z) >> 30;
      t = K9;
      t = K7 - ((z2 * t) >> 30);
      t = K5 - ((z2 * t) >> 30);
      t = K3 - ((z2 * t) >> 30);
      t = K1 - ((z2 * t) >> 30);
      s = (z * t) >> 30;
      v = (s + ROUND_Q) >> 16;
      if (v > SINE_MAX) begin
         v = SINE_MAX;
      end
      return quad[1] ? -(SINE_WIDTH'(v)) : SINE_WIDTH'(v);
   endfunction

endpackage

// ===== hdl/coherent_ask_psk_fsk_demodulator_core.sv =====
// channel   handshake              payload
// req       req_valid / req_stall  req_sample
// rsp       rsp_valid / rsp_stall  rsp_bit_value, rsp_correlation
// csr       apb write / read       csr_paddr, csr_pwdata, csr_prdata
//
// one sample at a time, req_stall high outside idle; the controller walks load, reference
// multiply, product multiply, accumulate, then difference and decision at a period end;
// the decision waits in its last step while the previous item is still stalled on rsp
// synchronous active-high reset clears phases, sums, period count and last bit
module coherent_ask_psk_fsk_demodulator_core #(
   parameter int SINE_TABLE_DEPTH = cdemod_pkg::SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = cdemod_pkg::SAMPLE_WIDTH,
   parameter int ACC_WIDTH        = cdemod_pkg::ACC_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_bit_value,
   output logic signed [cdemod_pkg::CORR_WIDTH-1:0] rsp_correlation,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [cdemod_pkg::ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [cdemod_pkg::DATA_WIDTH-1:0]        csr_pwdata,
   output logic [cdemod_pkg::DATA_WIDTH-1:0]        csr_prdata,
   output logic                                     csr_pready
);

   cdemod_pkg::cfg_type    cfg;
   cdemod_pkg::cmd_type    cmd;
   cdemod_pkg::status_type status;

   cdemod_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cdemod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cdemod_dp #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .ACC_WIDTH        (ACC_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_correlation (rsp_correlation)
   );

endmodule

// ===== hdl/cdemod_csr.sv =====
module cdemod_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cdemod_pkg::ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [cdemod_pkg::DATA_WIDTH-1:0]     csr_pwdata,
   output logic [cdemod_pkg::DATA_WIDTH-1:0]     csr_prdata,
   output logic                                  csr_pready,
   output cdemod_pkg::cfg_type                   cfg
);

   cdemod_pkg::cfg_type cfg_ff;
   cdemod_pkg::cfg_type cfg_in;
   logic [2:0]          reg_index;
   logic                write_en;

   assign reg_index  = csr_paddr[4:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            cdemod_pkg::REG_MODE:    cfg_in.mode            = csr_pwdata[1:0];
            cdemod_pkg::REG_STEP_A:  cfg_in.phase_step_a    = csr_pwdata;
            cdemod_pkg::REG_STEP_B:  cfg_in.phase_step_b    = csr_pwdata;
            cdemod_pkg::REG_GAIN:    cfg_in.ref_gain        = csr_pwdata[15:0];
            cdemod_pkg::REG_THR_LOW: cfg_in.thresh_low      = csr_pwdata;
            cdemod_pkg::REG_THR_HI:  cfg_in.thresh_high     = csr_pwdata;
            cdemod_pkg::REG_SPB:     cfg_in.samples_per_bit = csr_pwdata[9:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= cdemod_pkg::RST_MODE;
         cfg_ff.phase_step_a    <= cdemod_pkg::RST_STEP_A;
         cfg_ff.phase_step_b    <= cdemod_pkg::RST_STEP_B;
         cfg_ff.ref_gain        <= cdemod_pkg::RST_GAIN;
         cfg_ff.thresh_low      <= cdemod_pkg::RST_THR_LOW;
         cfg_ff.thresh_high     <= cdemod_pkg::RST_THR_HI;
         cfg_ff.samples_per_bit <= cdemod_pkg::RST_SPB;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         cdemod_pkg::REG_MODE:    csr_prdata = {30'd0, cfg_ff.mode};
         cdemod_pkg::REG_STEP_A:  csr_prdata = cfg_ff.phase_step_a;
         cdemod_pkg::REG_STEP_B:  csr_prdata = cfg_ff.phase_step_b;
         cdemod_pkg::REG_GAIN:    csr_prdata = {16'd0, cfg_ff.ref_gain};
         cdemod_pkg::REG_THR_LOW: csr_prdata = cfg_ff.thresh_low;
         cdemod_pkg::REG_THR_HI:  csr_prdata = cfg_ff.thresh_high;
         cdemod_pkg::REG_SPB:     csr_prdata = {22'd0, cfg_ff.samples_per_bit};
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

// ===== hdl/cdemod_ctrl.sv =====
module cdemod_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cdemod_pkg::status_type status,
   output cdemod_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REF    = 3'd1;
   localparam logic [2:0] ST_PROD   = 3'd2;
   localparam logic [2:0] ST_ACC    = 3'd3;
   localparam logic [2:0] ST_DIFF   = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REF;
            end
         end
         ST_REF: begin
            cmd.ref_calc = 1'b1;
            state_in     = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_calc = 1'b1;
            state_in      = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.period_end ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               cmd.decide   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/cdemod_dp.sv =====
module cdemod_dp #(
   parameter int SINE_TABLE_DEPTH = cdemod_pkg::SINE_TABLE_DEPTH,
   parameter int SAMPLE_WIDTH     = cdemod_pkg::SAMPLE_WIDTH,
   parameter int ACC_WIDTH        = cdemod_pkg::ACC_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cdemod_pkg::cfg_type                     cfg,
   input  cdemod_pkg::cmd_type                     cmd,
   output cdemod_pkg::status_type                  status,
   input  logic signed [SAMPLE_WIDTH-1:0]          req_sample,
   output logic                                    rsp_bit_value,
   output logic signed [cdemod_pkg::CORR_WIDTH-1:0] rsp_correlation
);

   localparam int IDX_WIDTH   = $clog2(SINE_TABLE_DEPTH);
   localparam int SW          = cdemod_pkg::SINE_WIDTH;
   localparam int RW          = cdemod_pkg::REF_WIDTH;
   localparam int PW          = cdemod_pkg::PHASE_WIDTH;
   localparam int CW          = cdemod_pkg::CNT_WIDTH;
   localparam int WW          = cdemod_pkg::WIDE_WIDTH;
   localparam int GAIN_FULL   = SW + 17;
   localparam int PRODA_FULL  = SAMPLE_WIDTH + RW;
   localparam int PRODB_FULL  = SAMPLE_WIDTH + SW;
   localparam int PRODA_WIDTH = PRODA_FULL - cdemod_pkg::FRAC_SHIFT;
   localparam int PRODB_WIDTH = PRODB_FULL - cdemod_pkg::FRAC_SHIFT;

   typedef logic signed [SW-1:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         r[k] = cdemod_pkg::sine_value(k, IDX_WIDTH);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a,
      input logic signed [ACC_WIDTH-1:0] b,
      input logic                        sub
   );
      logic signed [ACC_WIDTH:0] e;
      e = sub ? ((ACC_WIDTH+1)'(a) - (ACC_WIDTH+1)'(b))
              : ((ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b));
      if (e[ACC_WIDTH] != e[ACC_WIDTH-1]) begin
         return e[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      return e[ACC_WIDTH-1:0];
   endfunction

   logic signed [SAMPLE_WIDTH-1:0] sample_ff,  sample_in;
   logic [PW-1:0]                  phase_a_ff, phase_a_in;
   logic [PW-1:0]                  phase_b_ff, phase_b_in;
   logic signed [SW-1:0]           sine_a_ff,  sine_b_ff;
   logic signed [RW-1:0]           ref_ff,     ref_in;
   logic signed [PRODA_WIDTH-1:0]  prod_a_ff,  prod_a_in;
   logic signed [PRODB_WIDTH-1:0]  prod_b_ff,  prod_b_in;
   logic signed [ACC_WIDTH-1:0]    sum_a_ff,   sum_a_in;
   logic signed [ACC_WIDTH-1:0]    sum_b_ff,   sum_b_in;
   logic signed [ACC_WIDTH-1:0]    corr_ff,    corr_in;
   logic [CW-1:0]                  count_ff,   count_in;
   logic                           last_bit_ff, last_bit_in;
   logic                           rsp_bit_ff, rsp_bit_in;
   logic signed [cdemod_pkg::CORR_WIDTH-1:0] rsp_corr_ff, rsp_corr_in;

   logic                           fsk;
   logic signed [GAIN_FULL-1:0]    gain_prod;
   logic signed [PRODA_FULL-1:0]   prod_a_full;
   logic signed [PRODB_FULL-1:0]   prod_b_full;
   logic [CW-1:0]                  count_next;
   logic [CW-1:0]                  period_len;
   logic signed [WW-1:0]           corr_wide;
   logic signed [WW-1:0]           low_wide;
   logic signed [WW-1:0]           high_wide;
   logic                           decided;

   assign fsk         = cfg.mode[1];
   assign gain_prod   = GAIN_FULL'(sine_a_ff) * GAIN_FULL'($signed({1'b0, cfg.ref_gain}));
   assign prod_a_full = PRODA_FULL'(sample_ff) * PRODA_FULL'(ref_ff);
   assign prod_b_full = PRODB_FULL'(sample_ff) * PRODB_FULL'(sine_b_ff);
   assign count_next  = count_ff + CW'(1);
   assign period_len  = (cfg.samples_per_bit == '0) ? CW'(1) : cfg.samples_per_bit;
   assign status.period_end = !(count_next < period_len);
   assign corr_wide   = WW'(corr_ff);
   assign low_wide    = WW'(cfg.thresh_low);
   assign high_wide   = WW'(cfg.thresh_high);

   always_comb begin
      priority if (corr_wide < low_wide) begin
         decided = fsk;
      end else if (corr_wide > high_wide) begin
         decided = !fsk;
      end else begin
         decided = last_bit_ff;
      end
   end

   always_comb begin
      sample_in   = sample_ff;
      phase_a_in  = phase_a_ff;
      phase_b_in  = phase_b_ff;
      ref_in      = ref_ff;
      prod_a_in   = prod_a_ff;
      prod_b_in   = prod_b_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      corr_in     = corr_ff;
      count_in    = count_ff;
      last_bit_in = last_bit_ff;
      rsp_bit_in  = rsp_bit_ff;
      rsp_corr_in = rsp_corr_ff;
      if (cmd.load) begin
         sample_in = req_sample;
      end
      if (cmd.ref_calc) begin
         priority if (fsk) begin
            ref_in = RW'(sine_a_ff);
         end else if (cfg.mode == cdemod_pkg::MODE_PSK) begin
            ref_in = -RW'(sine_a_ff);
         end else begin
            ref_in = RW'(gain_prod >>> cdemod_pkg::GAIN_SHIFT);
         end
         prod_b_in  = PRODB_WIDTH'(prod_b_full >>> cdemod_pkg::FRAC_SHIFT);
         phase_a_in = phase_a_ff + cfg.phase_step_a;
         phase_b_in = phase_b_ff + cfg.phase_step_b;
      end
      if (cmd.prod_calc) begin
         prod_a_in = PRODA_WIDTH'(prod_a_full >>> cdemod_pkg::FRAC_SHIFT);
      end
      if (cmd.acc) begin
         sum_a_in = sat_add(sum_a_ff, ACC_WIDTH'(prod_a_ff), 1'b0);
         if (fsk) begin
            sum_b_in = sat_add(sum_b_ff, ACC_WIDTH'(prod_b_ff), 1'b0);
         end
         count_in = count_next;
      end
      if (cmd.diff) begin
         corr_in = fsk ? sat_add(sum_a_ff, sum_b_ff, 1'b1) : sum_a_ff;
      end
      if (cmd.decide) begin
         last_bit_in = decided;
         rsp_bit_in  = decided;
         rsp_corr_in = corr_wide[cdemod_pkg::CORR_WIDTH-1:0];
         sum_a_in    = '0;
         sum_b_in    = '0;
         count_in    = '0;
      end
   end

   // sine rom, registered read for both carriers
   always_ff @(posedge clock) begin
      sine_a_ff <= SINE_ROM[phase_a_ff[PW-1 -: IDX_WIDTH]];
      sine_b_ff <= SINE_ROM[phase_b_ff[PW-1 -: IDX_WIDTH]];
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      ref_ff      <= ref_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      corr_ff     <= corr_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_corr_ff <= rsp_corr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_a_ff  <= '0;
         phase_b_ff  <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         count_ff    <= '0;
         last_bit_ff <= 1'b0;
      end else begin
         phase_a_ff  <= phase_a_in;
         phase_b_ff  <= phase_b_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         count_ff    <= count_in;
         last_bit_ff <= last_bit_in;
      end
   end

   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_correlation = rsp_corr_ff;

endmodule
